// ===== src/windowed_nearest_waypoint_search_defines.svh =====
// ----------------------------------------------------------------------------
// Windowed nearest waypoint search: assertion macros
// Shared property shapes; every module that uses them has ports named clock
// and reset.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_NEAREST_WAYPOINT_SEARCH_DEFINES_SVH
`define WINDOWED_NEAREST_WAYPOINT_SEARCH_DEFINES_SVH

// Same-cycle implication, idle while reset is high.
`define WNWS_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, idle while reset is high.
`define WNWS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/wnws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed nearest waypoint search package
// Field widths, register indexes, reset values and shared structs.
// ----------------------------------------------------------------------------
package wnws_pkg;

   // Fixed field widths
   localparam int COORD_W   = 20;
   localparam int SEC_W     = 8;
   localparam int IDX_IN_W  = 10;
   localparam int PATH_W    = 2;
   localparam int COUNT_W   = 11;
   localparam int LIMIT_W   = 40;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 40;
   localparam int COUNT_REGS = 4;

   // Distance arithmetic
   localparam int ABS_W = COORD_W;
   localparam int SQ_W  = 2 * COORD_W;
   localparam int SUM_W = SQ_W + 2;

   // Parameter defaults
   localparam int MAX_POINTS_DEF    = 1024;
   localparam int NUM_PATHS_DEF     = 4;
   localparam int WINDOW_BEHIND_DEF = 3;
   localparam int WINDOW_AHEAD_DEF  = 6;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PATH_COUNT_0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATH_COUNT_1  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATH_COUNT_2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PATH_COUNT_3  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_ANY     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_SECTION = 3'd5;

   // Register reset values
   localparam logic [COUNT_W-1:0] COUNT_RESET         = 11'd1024;
   localparam logic [LIMIT_W-1:0] LIMIT_ANY_RESET     = 40'd40960000;
   localparam logic [LIMIT_W-1:0] LIMIT_SECTION_RESET = 40'd64000000;

   // Action codes
   localparam logic ACTION_WRITE  = 1'b0;
   localparam logic ACTION_SEARCH = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [SEC_W-1:0]          section;
   } waypoint_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [SEC_W-1:0]          section;
      logic                      use_section;
   } query_type;

   typedef struct packed {
      logic valid;
      logic last;
   } sample_type;

   typedef struct packed {
      logic done;
      logic found;
   } result_type;

endpackage

// ===== src/wnws_mod_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring division, one dividend bit per cycle; returns dividend mod divisor.
// ----------------------------------------------------------------------------
`include "windowed_nearest_waypoint_search_defines.svh"

module wnws_mod_unit #(
   parameter int  MAX_POINTS = wnws_pkg::MAX_POINTS_DEF,
   localparam int CNT_W      = $clog2(MAX_POINTS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [wnws_pkg::IDX_IN_W-1:0] dividend,
   input  logic [CNT_W-1:0]              divisor,
   output logic                          done,
   output logic [CNT_W-1:0]              remainder
);
   import wnws_pkg::*;

   localparam int IT_W = $clog2(IDX_IN_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [IT_W-1:0]     it_ff, it_in;
   logic [IDX_IN_W-1:0] dvd_ff, dvd_in;
   logic [CNT_W-1:0]    div_ff, div_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [CNT_W:0]      trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      it_in   = it_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[IDX_IN_W-1]};
      if (start) begin
         busy_in = 1'b1;
         it_in   = IT_W'(IDX_IN_W);
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // shift in the next bit, subtract when it fits
         if (trial >= {1'b0, div_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = CNT_W'(trial);
         end
         dvd_in = dvd_ff << 1;
         it_in  = it_ff - 1'b1;
         if (it_ff == IT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         it_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         it_ff   <= it_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   `WNWS_ASSERT_IMPLIES(a_rem_below_divisor, done_ff, rem_ff < div_ff, "remainder not below divisor")
   `WNWS_ASSERT_NEXT(a_done_ends_busy, done_ff, !busy_ff || start, "unit busy after done")

endmodule

// ===== src/wnws_dist_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance pipeline
// Squared distance of each streamed waypoint to the query, running minimum.
// ----------------------------------------------------------------------------
module wnws_dist_pipe #(
   parameter int  MAX_POINTS = wnws_pkg::MAX_POINTS_DEF,
   localparam int IDX_W      = $clog2(MAX_POINTS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  logic [wnws_pkg::LIMIT_W-1:0] limit,
   input  wnws_pkg::query_type          query,
   input  wnws_pkg::sample_type         sample,
   input  logic [IDX_W-1:0]             sample_idx,
   input  wnws_pkg::waypoint_type       waypoint,
   output wnws_pkg::result_type         result,
   output logic [IDX_W-1:0]             result_idx
);
   import wnws_pkg::*;

   logic signed [COORD_W:0] dx, dy, dz;

   // stage 1: absolute differences and section match
   sample_type       s1_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic [ABS_W-1:0] s1_ax_ff, s1_ay_ff, s1_az_ff;
   logic             s1_match_ff;
   // stage 2: squares
   sample_type       s2_ff;
   logic [IDX_W-1:0] s2_idx_ff;
   logic [SQ_W-1:0]  s2_sx_ff, s2_sy_ff, s2_sz_ff;
   logic             s2_match_ff;
   // stage 3: sum
   sample_type       s3_ff;
   logic [IDX_W-1:0] s3_idx_ff;
   logic [SUM_W-1:0] s3_sum_ff;
   logic             s3_match_ff;
   // running minimum
   logic [LIMIT_W-1:0] best_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic               found_ff;
   logic               done_ff;

   assign dx = {waypoint.x[COORD_W-1], waypoint.x} - {query.x[COORD_W-1], query.x};
   assign dy = {waypoint.y[COORD_W-1], waypoint.y} - {query.y[COORD_W-1], query.y};
   assign dz = {waypoint.z[COORD_W-1], waypoint.z} - {query.z[COORD_W-1], query.z};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= '0;
         s2_ff   <= '0;
         s3_ff   <= '0;
         done_ff <= 1'b0;
      end else begin
         s1_ff   <= sample;
         s2_ff   <= s1_ff;
         s3_ff   <= s2_ff;
         done_ff <= s3_ff.valid && s3_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff   <= sample_idx;
      s1_ax_ff    <= dx[COORD_W] ? ABS_W'(-dx) : ABS_W'(dx);
      s1_ay_ff    <= dy[COORD_W] ? ABS_W'(-dy) : ABS_W'(dy);
      s1_az_ff    <= dz[COORD_W] ? ABS_W'(-dz) : ABS_W'(dz);
      s1_match_ff <= !query.use_section || (waypoint.section == query.section);

      s2_idx_ff   <= s1_idx_ff;
      s2_sx_ff    <= SQ_W'(s1_ax_ff) * SQ_W'(s1_ax_ff);
      s2_sy_ff    <= SQ_W'(s1_ay_ff) * SQ_W'(s1_ay_ff);
      s2_sz_ff    <= SQ_W'(s1_az_ff) * SQ_W'(s1_az_ff);
      s2_match_ff <= s1_match_ff;

      s3_idx_ff   <= s2_idx_ff;
      s3_sum_ff   <= SUM_W'(s2_sx_ff) + SUM_W'(s2_sy_ff) + SUM_W'(s2_sz_ff);
      s3_match_ff <= s2_match_ff;
   end

   // strict compare: first waypoint in scan order wins a tie
   always_ff @(posedge clock) begin
      if (clear) begin
         best_ff     <= limit;
         best_idx_ff <= '0;
         found_ff    <= 1'b0;
      end else if (s3_ff.valid && s3_match_ff && (s3_sum_ff < SUM_W'(best_ff))) begin
         best_ff     <= LIMIT_W'(s3_sum_ff);
         best_idx_ff <= s3_idx_ff;
         found_ff    <= 1'b1;
      end
   end

   assign result.done  = done_ff;
   assign result.found = found_ff;
   assign result_idx   = best_idx_ff;

endmodule

// ===== src/windowed_nearest_waypoint_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed nearest waypoint search
// Waypoint store for closed paths with a windowed nearest-waypoint lookup.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per transfer. A write item (req_action = 0) stores
//   a waypoint at the transfer edge and returns nothing; the next item may
//   follow in the very next cycle. A search item (req_action = 1) returns one
//   rsp_* transfer: rsp_found and rsp_nearest_index of the last waypoint in
//   scan order whose squared distance is strictly below the running minimum,
//   which starts at the selected limit.
//   A search runs a remainder step for start mod count, steps back WINDOW_BEHIND
//   entries, then reads one window entry per cycle from the single waypoint
//   memory port into the distance pipeline (absolute differences, squares,
//   sum, running minimum); the next item is taken once the result is loaded
//   into the response register.
//   The result sits in an output register: a stalled rsp_ready does not block
//   req_ready; only a second finished search waits for the register to free.
//   Reset clears control state and the registers to their defaults; the
//   waypoint memory is not cleared and an entry must be written before any
//   search reads it. Configuration writes (csr_*) take effect at once; the user
//   must issue them only while no search is in flight; the block does not check.
// ----------------------------------------------------------------------------
`include "windowed_nearest_waypoint_search_defines.svh"

module windowed_nearest_waypoint_search #(
   parameter int MAX_POINTS    = wnws_pkg::MAX_POINTS_DEF,
   parameter int NUM_PATHS     = wnws_pkg::NUM_PATHS_DEF,
   parameter int WINDOW_BEHIND = wnws_pkg::WINDOW_BEHIND_DEF,
   parameter int WINDOW_AHEAD  = wnws_pkg::WINDOW_AHEAD_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic [wnws_pkg::PATH_W-1:0]         req_path_select,
   input  logic [wnws_pkg::IDX_IN_W-1:0]       req_entry_index,
   input  logic [wnws_pkg::IDX_IN_W-1:0]       req_start_index,
   input  logic signed [wnws_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [wnws_pkg::COORD_W-1:0] req_coord_y,
   input  logic signed [wnws_pkg::COORD_W-1:0] req_coord_z,
   input  logic [wnws_pkg::SEC_W-1:0]          req_section,
   input  logic                                req_use_section,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic [wnws_pkg::IDX_IN_W-1:0]       rsp_nearest_index,
   // configuration port
   input  logic                                csr_wr_en,
   input  logic [wnws_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wnws_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import wnws_pkg::*;

   localparam int IDX_W   = $clog2(MAX_POINTS);
   localparam int CNT_W   = $clog2(MAX_POINTS + 1);
   localparam int EXT_W   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int ENT_W   = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;
   localparam int DEPTH   = NUM_PATHS * MAX_POINTS;
   localparam int AW      = $clog2(DEPTH);
   localparam int WIN_N   = WINDOW_BEHIND + WINDOW_AHEAD + 1;
   localparam int BACK_W  = $clog2(WINDOW_BEHIND + 2);
   localparam int SCAN_W  = $clog2(WIN_N + 1);
   localparam int PSEL_W  = 4;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MOD  = 6'b000010,
      ST_BACK = 6'b000100,
      ST_SCAN = 6'b001000,
      ST_WAIT = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   // waypoint memory
   waypoint_type mem [DEPTH];
   waypoint_type rd_data_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          mem_we;
   waypoint_type  wr_data;

   // configuration registers
   logic [COUNT_W-1:0] count_ff [COUNT_REGS];
   logic [LIMIT_W-1:0] limit_any_ff, limit_sec_ff;

   // sequencer
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [PATH_W-1:0] path_ff, path_in;
   logic [BACK_W-1:0] back_ff, back_in;
   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic              miss_ff, miss_in;
   query_type         query_ff, query_in;

   // read tag, aligned with rd_data_ff
   sample_type       rd_tag_ff;
   logic [IDX_W-1:0] rd_idx_ff;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [IDX_IN_W-1:0] rsp_index_ff, rsp_index_in;

   // request decode
   logic              req_fire, req_search, path_ok, entry_ok;
   logic [COUNT_W-1:0] count_sel;
   logic [CNT_W-1:0]  req_cnt;
   logic [LIMIT_W-1:0] req_limit;
   logic              scan_last;
   logic [IDX_W-1:0]  idx_fwd, idx_bwd;

   // submodule links
   logic             mod_done;
   logic [CNT_W-1:0] mod_rem;
   result_type       dist_res;
   logic [IDX_W-1:0] dist_idx;
   sample_type       scan_tag;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign req_search = (req_action == ACTION_SEARCH);
   assign path_ok    = (PSEL_W'(req_path_select) < PSEL_W'(NUM_PATHS));
   assign entry_ok   = (ENT_W'(req_entry_index) < ENT_W'(MAX_POINTS));

   // effective count: zero reads as one, saturate at the table size
   assign count_sel = count_ff[req_path_select];
   always_comb begin
      if (count_sel == '0) begin
         req_cnt = CNT_W'(1);
      end else if (EXT_W'(count_sel) > EXT_W'(MAX_POINTS)) begin
         req_cnt = CNT_W'(MAX_POINTS);
      end else begin
         req_cnt = CNT_W'(count_sel);
      end
   end

   assign req_limit = req_use_section ? limit_sec_ff : limit_any_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COUNT_REGS; i++) begin
            count_ff[i] <= COUNT_RESET;
         end
         limit_any_ff <= LIMIT_ANY_RESET;
         limit_sec_ff <= LIMIT_SECTION_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PATH_COUNT_0:  count_ff[0]  <= csr_wdata[COUNT_W-1:0];
            CSR_PATH_COUNT_1:  count_ff[1]  <= csr_wdata[COUNT_W-1:0];
            CSR_PATH_COUNT_2:  count_ff[2]  <= csr_wdata[COUNT_W-1:0];
            CSR_PATH_COUNT_3:  count_ff[3]  <= csr_wdata[COUNT_W-1:0];
            CSR_LIMIT_ANY:     limit_any_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_LIMIT_SECTION: limit_sec_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // memory write at the request transfer; ignore out-of-range slots
   assign mem_we          = req_fire && (req_action == ACTION_WRITE) && path_ok && entry_ok;
   assign wr_addr         = AW'(req_path_select) * AW'(MAX_POINTS) + AW'(req_entry_index);
   assign wr_data.x       = req_coord_x;
   assign wr_data.y       = req_coord_y;
   assign wr_data.z       = req_coord_z;
   assign wr_data.section = req_section;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // window read, one entry per cycle
   assign rd_addr = AW'(path_ff) * AW'(MAX_POINTS) + AW'(idx_ff);

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   // circular neighbors of the current index
   assign idx_fwd = (CNT_W'(idx_ff) == cnt_ff - 1'b1) ? '0 : idx_ff + 1'b1;
   assign idx_bwd = (idx_ff == '0) ? IDX_W'(cnt_ff - 1'b1) : idx_ff - 1'b1;

   assign scan_last      = (scan_ff == SCAN_W'(WIN_N - 1));
   assign scan_tag.valid = (state_ff == ST_SCAN);
   assign scan_tag.last  = scan_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_tag_ff <= '0;
      end else begin
         rd_tag_ff <= scan_tag;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= idx_ff;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      path_in      = path_ff;
      back_in      = back_ff;
      scan_in      = scan_ff;
      miss_in      = miss_ff;
      query_in     = query_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_search) begin
               // latch the query; an absent path answers with no match
               query_in.x           = req_coord_x;
               query_in.y           = req_coord_y;
               query_in.z           = req_coord_z;
               query_in.section     = req_section;
               query_in.use_section = req_use_section;
               path_in              = req_path_select;
               cnt_in               = req_cnt;
               miss_in              = !path_ok;
               state_in             = path_ok ? ST_MOD : ST_DONE;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               idx_in  = IDX_W'(mod_rem);
               back_in = BACK_W'(WINDOW_BEHIND);
               scan_in = '0;
               state_in = (WINDOW_BEHIND == 0) ? ST_SCAN : ST_BACK;
            end
         end
         ST_BACK: begin
            idx_in  = idx_bwd;
            back_in = back_ff - 1'b1;
            if (back_ff == BACK_W'(1)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            idx_in  = idx_fwd;
            scan_in = scan_ff + 1'b1;
            if (scan_last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (dist_res.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = dist_res.found && !miss_ff;
               rsp_index_in = (dist_res.found && !miss_ff) ? IDX_IN_W'(dist_idx) : '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         back_ff      <= '0;
         scan_ff      <= '0;
         miss_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         back_ff      <= back_in;
         scan_ff      <= scan_in;
         miss_ff      <= miss_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      idx_ff       <= idx_in;
      path_ff      <= path_in;
      query_ff     <= query_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
   end

   wnws_mod_unit #(
      .MAX_POINTS (MAX_POINTS)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (req_fire && req_search && path_ok),
      .dividend  (req_start_index),
      .divisor   (req_cnt),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   wnws_dist_pipe #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dist (
      .clock      (clock),
      .reset      (reset),
      .clear      (req_fire && req_search),
      .limit      (req_limit),
      .query      (query_ff),
      .sample     (rd_tag_ff),
      .sample_idx (rd_idx_ff),
      .waypoint   (rd_data_ff),
      .result     (dist_res),
      .result_idx (dist_idx)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_nearest_index = rsp_index_ff;

   `WNWS_ASSERT_IMPLIES(a_scan_idx_in_range, state_ff == ST_SCAN, CNT_W'(idx_ff) < cnt_ff, "window index beyond path count")
   `WNWS_ASSERT_IMPLIES(a_dist_done_in_wait, dist_res.done, state_ff == ST_WAIT, "distance result outside wait")
   `WNWS_ASSERT_IMPLIES(a_mod_done_in_mod, mod_done, state_ff == ST_MOD, "remainder done outside mod phase")
   `WNWS_ASSERT_NEXT(a_scan_exit, (state_ff == ST_SCAN) && scan_last, state_ff == ST_WAIT, "scan did not end after last entry")

endmodule
